[rtl/core/pat_pkg.sv]
package pat_pkg;

	localparam int unsigned VA_W = 32;
	localparam int unsigned SHIFT_W = 5;
	localparam int unsigned COUNT_W = 7;

	localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd2;
	localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd20;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

	localparam logic CMD_TRANSLATE = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	localparam logic [1:0] ST_HIT = 2'd0;
	localparam logic [1:0] ST_FAULT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NEW = 2'd3;

	typedef struct packed {
		logic command;
		logic [VA_W-1:0] vaddr;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [VA_W-1:0] paddr;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	function automatic logic [SHIFT_W-1:0] clamp_shift(input logic [SHIFT_W-1:0] s);
		logic [SHIFT_W-1:0] r;
		r = s;
		if (s < SHIFT_MIN) begin
			r = SHIFT_MIN;
		end else if (s > SHIFT_MAX) begin
			r = SHIFT_MAX;
		end
		return r;
	endfunction

endpackage

[rtl/core/pat_store.sv]
module pat_store #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 32,
	parameter int unsigned AW = 6
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/pat_scan.sv]
module pat_scan #(
	parameter int unsigned ENTRIES = 64,
	parameter int unsigned AW = 6,
	parameter int unsigned CNT_W = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  pat_pkg::req_t             req,
	input  logic [pat_pkg::SHIFT_W-1:0] shift,
	output logic                      res_valid,
	input  logic                      res_ready,
	output pat_pkg::rsp_t             res,
	output logic [CNT_W-1:0]          pages_used,
	output logic                      rd_en,
	output logic [AW-1:0]             rd_addr,
	input  logic [pat_pkg::VA_W-1:0]  rd_data,
	output logic                      wr_en,
	output logic [AW-1:0]             wr_addr,
	output logic [pat_pkg::VA_W-1:0]  wr_data
);

	pat_pkg::state_t state_q, state_nx;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_inc;
	logic [CNT_W-1:0] hit_idx_q;
	logic hit_q;
	logic cmd_q;
	logic [pat_pkg::VA_W-1:0] va_q;
	logic [pat_pkg::VA_W-1:0] mask_q;
	logic [pat_pkg::SHIFT_W-1:0] shift_q;
	logic [pat_pkg::SHIFT_W-1:0] shift_eff;

	logic accept;
	logic match;
	logic last;
	logic full;
	logic is_new;
	logic commit;
	logic [CNT_W-1:0] count_nx;
	logic [pat_pkg::VA_W-1:0] base_hit;
	logic [pat_pkg::VA_W-1:0] base_new;
	logic [31:0] count_ext;

	assign shift_eff = pat_pkg::clamp_shift(shift);
	assign accept = req_valid && req_ready;
	assign idx_inc = idx_q + CNT_W'(1);
	// mask_q keeps the page-number bits
	assign match = ((rd_data ^ va_q) & mask_q) == '0;
	assign last = idx_inc == count_q;
	assign full = count_q >= CNT_W'(ENTRIES);
	assign is_new = cmd_q == pat_pkg::CMD_INSERT && !hit_q && !full;
	assign commit = res_valid && res_ready;
	assign count_nx = is_new ? count_q + CNT_W'(1) : count_q;
	assign base_hit = pat_pkg::VA_W'(hit_idx_q) << shift_q;
	assign base_new = pat_pkg::VA_W'(count_q) << shift_q;
	assign count_ext = 32'(count_nx);
	assign pages_used = count_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			pat_pkg::S_IDLE: begin
				if (accept) begin
					state_nx = (count_q == '0) ? pat_pkg::S_DONE : pat_pkg::S_SCAN;
				end
			end
			pat_pkg::S_SCAN: begin
				if (match || last) begin
					state_nx = pat_pkg::S_DONE;
				end
			end
			pat_pkg::S_DONE: begin
				if (res_ready) begin
					state_nx = pat_pkg::S_IDLE;
				end
			end
			default: state_nx = pat_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		case (state_q)
			pat_pkg::S_IDLE: begin
				req_ready = 1'b1;
				rd_en = req_valid;
			end
			pat_pkg::S_SCAN: begin
				rd_en = !match && !last;
				rd_addr = idx_inc[AW-1:0];
			end
			pat_pkg::S_DONE: begin
				res_valid = 1'b1;
				wr_en = is_new && res_ready;
			end
			default: begin
			end
		endcase
	end

	assign wr_addr = count_q[AW-1:0];
	assign wr_data = va_q & mask_q;

	always_comb begin
		res.status = pat_pkg::ST_FAULT;
		res.paddr = '0;
		if (hit_q) begin
			res.status = pat_pkg::ST_HIT;
			res.paddr = (cmd_q == pat_pkg::CMD_TRANSLATE)
				? (base_hit | (va_q & ~mask_q)) : base_hit;
		end else if (cmd_q == pat_pkg::CMD_INSERT) begin
			if (full) begin
				res.status = pat_pkg::ST_FULL;
			end else begin
				res.status = pat_pkg::ST_NEW;
				res.paddr = base_new;
			end
		end
		res.entry_count = count_ext[pat_pkg::COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pat_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nx;
			if (commit) begin
				count_q <= count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			va_q <= req.vaddr;
			shift_q <= shift_eff;
			mask_q <= ~((pat_pkg::VA_W'(1) << shift_eff) - pat_pkg::VA_W'(1));
			idx_q <= '0;
			hit_q <= 1'b0;
		end else if (state_q == pat_pkg::S_SCAN) begin
			if (match) begin
				hit_q <= 1'b1;
				hit_idx_q <= idx_q;
			end else begin
				idx_q <= idx_inc;
			end
		end
	end

endmodule

[rtl/core/page_table_alloc_translate.sv]
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_data  (command, vaddr)
// out     | out | out_valid/out_ready | out_data (status, paddr, entry_count)
// cfg     | in  | cfg_valid/cfg_ready | cfg_data (page_shift)
// a request scans at most the n mapped pages, n being the page count (at most ENTRIES);
// the page memory has one read port, so the scan compares one entry per cycle, ending on a hit
// reset clears the page count and sets page_shift to 12; the page memory is not cleared
// a finished result waits in the output register; the next request is taken meanwhile
// and its scan holds at the end until the output register frees up
module page_table_alloc_translate #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  pat_pkg::req_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output pat_pkg::rsp_t               out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pat_pkg::SHIFT_W-1:0] cfg_data
);

	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

	logic [pat_pkg::SHIFT_W-1:0] page_shift_q;
	logic res_valid;
	logic res_ready;
	pat_pkg::rsp_t res;
	logic [CNT_W-1:0] pages_used;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic [pat_pkg::VA_W-1:0] rd_data;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [pat_pkg::VA_W-1:0] wr_data;
	logic out_valid_q;
	pat_pkg::rsp_t out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q <= pat_pkg::SHIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			page_shift_q <= cfg_data;
		end
	end

	pat_store #(
		.DEPTH(ENTRIES),
		.WIDTH(pat_pkg::VA_W),
		.AW(AW)
	) u_store (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	pat_scan #(
		.ENTRIES(ENTRIES),
		.AW(AW),
		.CNT_W(CNT_W)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(in_valid),
		.req_ready(in_ready),
		.req(in_data),
		.shift(page_shift_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.pages_used(pages_used),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == pat_pkg::ST_FAULT |-> out_data.paddr == '0)
		else $error("page fault with nonzero address");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == pat_pkg::ST_FULL |-> pages_used == CNT_W'(ENTRIES))
		else $error("table full reported below capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res.status == pat_pkg::ST_NEW
		|=> pages_used == $past(pages_used) + CNT_W'(1))
		else $error("insert did not grow page count");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while scan busy");

endmodule
